// File: src/adll_pkg.sv
// ----------------------------------------------------------------------------
// adll_pkg: shared types for the array doubly linked list
// Opcodes, status codes, controller states and the command/status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package adll_pkg;

  // request opcodes
  typedef enum logic [1:0] {
    OP_INS_AFTER  = 2'd0,
    OP_INS_BEFORE = 2'd1,
    OP_DELETE     = 2'd2,
    OP_READ       = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_WR1,
    S_WR2
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic clear;    // init sweep writes one slot
    logic accept;   // request taken this cycle
    logic eval;     // slot data valid, decide status
    logic wr1;      // first link update
    logic wr2;      // second link update
    logic respond;  // load result registers
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;  // sweep is at the last slot
    logic go_write;    // request passed checks and modifies the list
  } dp_sts_t;

endpackage

// File: src/adll_ram.sv
// ----------------------------------------------------------------------------
// adll_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module adll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/adll_ctl.sv
// ----------------------------------------------------------------------------
// adll_ctl: request sequencer
// Runs the init sweep after reset, then steps each request through
// evaluate and up to two link-update states.
// ----------------------------------------------------------------------------
module adll_ctl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  adll_pkg::dp_sts_t sts,
  output adll_pkg::ctl_cmd_t cmd,
  output logic              busy
);
  import adll_pkg::*;

  ctl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.go_write) begin
          state_nxt = S_WR1;
        end else begin
          cmd.respond = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_WR1: begin
        cmd.wr1   = 1'b1;
        state_nxt = S_WR2;
      end
      S_WR2: begin
        cmd.wr2     = 1'b1;
        cmd.respond = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

endmodule

// File: src/adll_dp.sv
// ----------------------------------------------------------------------------
// adll_dp: list datapath
// Slot stores (next, prev, free mark, word), head/tail/free-head/count
// registers, status checks, link update muxing and the result registers.
// ----------------------------------------------------------------------------
module adll_dp #(
  parameter int SLOT_COUNT = 255,
  parameter int WORD_BITS  = 64,
  localparam int SB        = $clog2(SLOT_COUNT + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  adll_pkg::ctl_cmd_t   cmd,
  output adll_pkg::dp_sts_t    sts,
  // request
  input  logic [1:0]           in_opcode,
  input  logic [SB-1:0]        in_slot_index,
  input  logic [WORD_BITS-1:0] in_data_word,
  // configuration
  input  logic                 cfg_wr,
  input  logic [WORD_BITS-1:0] cfg_poison_word,
  // result
  output logic                 out_strobe,
  output logic [1:0]           out_status,
  output logic [SB-1:0]        out_used_slot,
  output logic [WORD_BITS-1:0] out_read_word,
  output logic [SB-1:0]        out_read_next,
  output logic [SB-1:0]        out_read_prev,
  output logic                 out_slot_is_free,
  output logic [SB-1:0]        out_head_slot,
  output logic [SB-1:0]        out_tail_slot,
  output logic [SB-1:0]        out_element_count,
  output logic [SB-1:0]        out_free_head_slot
);
  import adll_pkg::*;

  localparam int DEPTH = SLOT_COUNT + 1;
  localparam logic [SB-1:0] SLOT_MAX = SB'(SLOT_COUNT);
  localparam logic [SB-1:0] SLOT_ONE = SB'(1);

  // request and list registers
  op_t                  op_r;
  logic [SB-1:0]        idx_r;
  logic [WORD_BITS-1:0] data_r;
  logic [WORD_BITS-1:0] poison_r;
  logic [SB-1:0]        clr_r;
  logic [SB-1:0]        head_r, head_nxt;
  logic [SB-1:0]        tail_r, tail_nxt;
  logic [SB-1:0]        fhead_r, fhead_nxt;
  logic [SB-1:0]        count_r, count_nxt;
  logic [SB-1:0]        lnk_next_r, lnk_prev_r, nf_r;
  status_t              st_r, status_c;
  logic                 in_range, is_ins;

  // store ports
  logic                 next_we, prev_we, free_we, word_we;
  logic [SB-1:0]        next_wa, prev_wa, free_wa, word_wa;
  logic [SB-1:0]        next_wd, prev_wd;
  logic                 free_wd;
  logic [WORD_BITS-1:0] word_wd;
  logic [SB-1:0]        idx_ra, next_ra;
  logic [SB-1:0]        next_q, prev_q;
  logic                 free_q;
  logic [WORD_BITS-1:0] word_q;

  // result registers
  logic                 strobe_r;
  status_t              o_status_r;
  logic [SB-1:0]        o_used_r, o_rnext_r, o_rprev_r;
  logic [WORD_BITS-1:0] o_rword_r;
  logic                 o_rfree_r;
  logic [SB-1:0]        o_head_r, o_tail_r, o_count_r, o_fhead_r;

  // read addresses: request slot straight from the port on accept
  assign idx_ra  = cmd.accept ? in_slot_index : idx_r;
  assign next_ra = cmd.eval ? fhead_r : idx_ra;

  adll_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_next_ram (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
    .raddr(next_ra), .rdata(next_q)
  );

  adll_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_prev_ram (
    .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
    .raddr(idx_ra), .rdata(prev_q)
  );

  adll_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_free_ram (
    .clk(clk), .we(free_we), .waddr(free_wa), .wdata(free_wd),
    .raddr(idx_ra), .rdata(free_q)
  );

  adll_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_word_ram (
    .clk(clk), .we(word_we), .waddr(word_wa), .wdata(word_wd),
    .raddr(idx_ra), .rdata(word_q)
  );

  assign in_range = (idx_r <= SLOT_MAX);
  assign is_ins   = (op_r == OP_INS_AFTER) || (op_r == OP_INS_BEFORE);

  // status checks on the addressed slot
  always_comb begin
    status_c = ST_OK;
    case (op_r)
      OP_INS_AFTER, OP_INS_BEFORE: begin
        if (!in_range || free_q) begin
          status_c = ST_BAD;
        end else if (count_r >= SLOT_MAX || fhead_r == '0) begin
          status_c = ST_FULL;
        end
      end
      OP_DELETE: begin
        if (count_r == '0) begin
          status_c = ST_EMPTY;
        end else if (!in_range || idx_r == '0 || free_q) begin
          status_c = ST_BAD;
        end
      end
      OP_READ: begin
        if (!in_range) begin
          status_c = ST_BAD;
        end
      end
      default: status_c = ST_BAD;
    endcase
  end

  assign sts.go_write   = (status_c == ST_OK) && (op_r != OP_READ);
  assign sts.clear_last = (clr_r == SLOT_MAX);

  // store writes: init sweep, then two link-update steps per change
  always_comb begin
    next_we = 1'b0;  next_wa = '0;  next_wd = '0;
    prev_we = 1'b0;  prev_wa = '0;  prev_wd = '0;
    free_we = 1'b0;  free_wa = '0;  free_wd = 1'b0;
    word_we = 1'b0;  word_wa = '0;  word_wd = '0;
    if (cmd.clear) begin
      next_we = 1'b1;  next_wa = clr_r;
      next_wd = (clr_r == '0 || clr_r == SLOT_MAX) ? '0 : clr_r + SLOT_ONE;
      prev_we = 1'b1;  prev_wa = clr_r;
      free_we = 1'b1;  free_wa = clr_r;  free_wd = (clr_r != '0);
    end else if (cmd.wr1) begin
      case (op_r)
        OP_INS_AFTER: begin
          next_we = 1'b1;  next_wa = idx_r;      next_wd = fhead_r;
          prev_we = 1'b1;  prev_wa = fhead_r;    prev_wd = idx_r;
          free_we = 1'b1;  free_wa = fhead_r;    free_wd = 1'b0;
          word_we = 1'b1;  word_wa = fhead_r;    word_wd = data_r;
        end
        OP_INS_BEFORE: begin
          prev_we = 1'b1;  prev_wa = idx_r;      prev_wd = fhead_r;
          next_we = 1'b1;  next_wa = lnk_prev_r; next_wd = fhead_r;
          free_we = 1'b1;  free_wa = fhead_r;    free_wd = 1'b0;
          word_we = 1'b1;  word_wa = fhead_r;    word_wd = data_r;
        end
        OP_DELETE: begin
          next_we = 1'b1;  next_wa = lnk_prev_r; next_wd = lnk_next_r;
          prev_we = 1'b1;  prev_wa = lnk_next_r; prev_wd = lnk_prev_r;
          free_we = 1'b1;  free_wa = idx_r;      free_wd = 1'b1;
          word_we = 1'b1;  word_wa = idx_r;      word_wd = poison_r;
        end
        default: ;
      endcase
    end else if (cmd.wr2) begin
      case (op_r)
        OP_INS_AFTER: begin
          next_we = 1'b1;  next_wa = fhead_r;    next_wd = lnk_next_r;
          prev_we = 1'b1;  prev_wa = lnk_next_r; prev_wd = fhead_r;
        end
        OP_INS_BEFORE: begin
          prev_we = 1'b1;  prev_wa = fhead_r;    prev_wd = lnk_prev_r;
          next_we = 1'b1;  next_wa = fhead_r;    next_wd = idx_r;
        end
        OP_DELETE: begin
          next_we = 1'b1;  next_wa = idx_r;      next_wd = fhead_r;
          prev_we = 1'b1;  prev_wa = idx_r;      prev_wd = '0;
        end
        default: ;
      endcase
    end
  end

  // sentinel shadows and list counters
  always_comb begin
    head_nxt  = (next_we && next_wa == '0) ? next_wd : head_r;
    tail_nxt  = (prev_we && prev_wa == '0) ? prev_wd : tail_r;
    fhead_nxt = fhead_r;
    count_nxt = count_r;
    if (cmd.clear) begin
      fhead_nxt = SLOT_ONE;
      count_nxt = '0;
    end else if (cmd.wr2) begin
      if (is_ins) begin
        fhead_nxt = nf_r;
        count_nxt = count_r + SLOT_ONE;
      end else begin
        fhead_nxt = idx_r;
        count_nxt = count_r - SLOT_ONE;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r    <= '0;
      head_r   <= '0;
      tail_r   <= '0;
      fhead_r  <= SLOT_ONE;
      count_r  <= '0;
      poison_r <= '0;
      strobe_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_r <= clr_r + SLOT_ONE;
      end
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      fhead_r  <= fhead_nxt;
      count_r  <= count_nxt;
      if (cfg_wr) begin
        poison_r <= cfg_poison_word;
      end
      strobe_r <= cmd.respond;
    end
  end

  // request capture and link holding registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r   <= op_t'(in_opcode);
      idx_r  <= in_slot_index;
      data_r <= in_data_word;
    end
    if (cmd.eval) begin
      st_r       <= status_c;
      lnk_next_r <= next_q;
      lnk_prev_r <= prev_q;
    end
    if (cmd.wr1) begin
      nf_r <= next_q;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      o_status_r <= cmd.wr2 ? st_r : status_c;
      o_used_r   <= (cmd.wr2 && is_ins) ? fhead_r : idx_r;
      if (cmd.eval && op_r == OP_READ && status_c == ST_OK) begin
        o_rword_r <= word_q;
        o_rnext_r <= next_q;
        o_rprev_r <= prev_q;
        o_rfree_r <= free_q;
      end else begin
        o_rword_r <= '0;
        o_rnext_r <= '0;
        o_rprev_r <= '0;
        o_rfree_r <= 1'b0;
      end
      o_head_r  <= head_nxt;
      o_tail_r  <= tail_nxt;
      o_count_r <= count_nxt;
      o_fhead_r <= fhead_nxt;
    end
  end

  assign out_strobe         = strobe_r;
  assign out_status         = o_status_r;
  assign out_used_slot      = o_used_r;
  assign out_read_word      = o_rword_r;
  assign out_read_next      = o_rnext_r;
  assign out_read_prev      = o_rprev_r;
  assign out_slot_is_free   = o_rfree_r;
  assign out_head_slot      = o_head_r;
  assign out_tail_slot      = o_tail_r;
  assign out_element_count  = o_count_r;
  assign out_free_head_slot = o_fhead_r;

endmodule

// File: src/array_doubly_linked_list_top.sv
// ----------------------------------------------------------------------------
// array_doubly_linked_list_top: fixed-size doubly linked list with free list
// A request (insert after, insert before, delete, read slot) is taken at a
// clock edge with start high and busy low. Exactly one result follows,
// shown for one cycle with out_strobe high; the receiver cannot stall it.
// Read and rejected requests: accept, then evaluate, result strobe in the
// cycle after evaluate; next request may start with the strobe.
// Insert and delete: accept, evaluate and two link-update steps; the
// second update is needed because each link store has one write port and a
// change touches two slots of it.
// Every result carries head, tail, element count and free head after the
// request. After reset an init sweep writes the link and free-mark stores,
// one slot per cycle, over all SLOT_COUNT+1 slots; busy is high meanwhile.
// The user writes the poison word through cfg_valid/cfg_ready (always
// ready) only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module array_doubly_linked_list_top #(
  parameter int SLOT_COUNT = 255,
  parameter int WORD_BITS  = 64,
  localparam int SB        = $clog2(SLOT_COUNT + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_opcode,
  input  logic [SB-1:0]        in_slot_index,
  input  logic [WORD_BITS-1:0] in_data_word,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [WORD_BITS-1:0] cfg_poison_word,
  // result
  output logic                 out_strobe,
  output logic [1:0]           out_status,
  output logic [SB-1:0]        out_used_slot,
  output logic [WORD_BITS-1:0] out_read_word,
  output logic [SB-1:0]        out_read_next,
  output logic [SB-1:0]        out_read_prev,
  output logic                 out_slot_is_free,
  output logic [SB-1:0]        out_head_slot,
  output logic [SB-1:0]        out_tail_slot,
  output logic [SB-1:0]        out_element_count,
  output logic [SB-1:0]        out_free_head_slot
);
  import adll_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  assign cfg_ready = 1'b1;

  // sequencer
  adll_ctl u_ctl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // stores and result registers
  adll_dp #(
    .SLOT_COUNT (SLOT_COUNT),
    .WORD_BITS  (WORD_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_opcode          (in_opcode),
    .in_slot_index      (in_slot_index),
    .in_data_word       (in_data_word),
    .cfg_wr             (cfg_valid & cfg_ready),
    .cfg_poison_word    (cfg_poison_word),
    .out_strobe         (out_strobe),
    .out_status         (out_status),
    .out_used_slot      (out_used_slot),
    .out_read_word      (out_read_word),
    .out_read_next      (out_read_next),
    .out_read_prev      (out_read_prev),
    .out_slot_is_free   (out_slot_is_free),
    .out_head_slot      (out_head_slot),
    .out_tail_slot      (out_tail_slot),
    .out_element_count  (out_element_count),
    .out_free_head_slot (out_free_head_slot)
  );

  // a taken request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low right after a request was taken");

  // every respond command gives one strobe, and only then
  a_respond_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.respond |=> out_strobe)
    else $error("respond without result strobe");

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(cmd.respond))
    else $error("result strobe without respond");

  // free list empty exactly when the list is full
  a_full_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ((out_free_head_slot == '0) ==
                    (out_element_count == SB'(SLOT_COUNT))))
    else $error("free head and element count disagree");

endmodule

// File: tb/tb_array_doubly_linked_list_top.sv
// ----------------------------------------------------------------------------
// tb_array_doubly_linked_list_top: self-checking bench for the slot-store list
// Drives insert-after, insert-before, delete and read requests through the
// start/busy port. A behavioral copy of the list, updated when each request
// is taken, predicts every result. A checker compares each strobed result
// field by field against the oldest prediction. The poison word is changed
// between phases while the block is idle. Directed cases come first, then
// random phases: a mixed phase, a fill to full, a mostly-delete phase and a
// final mix.
// ----------------------------------------------------------------------------
module tb_array_doubly_linked_list_top;
  import adll_pkg::*;

  localparam int SLOT_COUNT = 255;
  localparam int WORD_BITS  = 64;
  localparam int SB         = 8;

  typedef logic [SB-1:0]        slot_t;
  typedef logic [WORD_BITS-1:0] word_t;

  // one predicted result
  typedef struct packed {
    status_t status;
    slot_t   used_slot;
    word_t   read_word;
    slot_t   read_next;
    slot_t   read_prev;
    logic    slot_is_free;
    slot_t   head_slot;
    slot_t   tail_slot;
    slot_t   element_count;
    slot_t   free_head_slot;
  } list_result_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         start;
  logic         busy;
  logic [1:0]   in_opcode;
  slot_t        in_slot_index;
  word_t        in_data_word;
  logic         cfg_valid;
  logic         cfg_ready;
  word_t        cfg_poison_word;
  logic         out_strobe;
  logic [1:0]   out_status;
  slot_t        out_used_slot;
  word_t        out_read_word;
  slot_t        out_read_next;
  slot_t        out_read_prev;
  logic         out_slot_is_free;
  slot_t        out_head_slot;
  slot_t        out_tail_slot;
  slot_t        out_element_count;
  slot_t        out_free_head_slot;

  array_doubly_linked_list_top #(
    .SLOT_COUNT(SLOT_COUNT),
    .WORD_BITS (WORD_BITS)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_slot_index     (in_slot_index),
    .in_data_word      (in_data_word),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_poison_word   (cfg_poison_word),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_used_slot     (out_used_slot),
    .out_read_word     (out_read_word),
    .out_read_next     (out_read_next),
    .out_read_prev     (out_read_prev),
    .out_slot_is_free  (out_slot_is_free),
    .out_head_slot     (out_head_slot),
    .out_tail_slot     (out_tail_slot),
    .out_element_count (out_element_count),
    .out_free_head_slot(out_free_head_slot)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // behavioral copy of the list
  slot_t next_link    [0:SLOT_COUNT];
  slot_t prev_link    [0:SLOT_COUNT];
  bit    free_mark    [0:SLOT_COUNT];
  word_t slot_word    [0:SLOT_COUNT];
  bit    word_written [0:SLOT_COUNT];
  slot_t free_top;
  slot_t elem_count;
  word_t poison_copy;

  list_result_t pending_results[$];
  int fail_count = 0;
  int burst_left = 0;
  bit steady     = 1'b0;

  // state right after reset: free chain in slot order
  function automatic void clear_list_model();
    for (int k = 0; k <= SLOT_COUNT; k++) begin
      next_link[k]    = (k == 0 || k == SLOT_COUNT) ? slot_t'(0) : slot_t'(k + 1);
      prev_link[k]    = '0;
      free_mark[k]    = (k != 0);
      slot_word[k]    = '0;
      word_written[k] = 1'b0;
    end
    free_top    = slot_t'(1);
    elem_count  = '0;
    poison_copy = '0;
  endfunction

  // apply one request to the copy and return its result
  function automatic list_result_t apply_list_op(op_t op, slot_t idx, word_t data);
    list_result_t r;
    slot_t f;
    slot_t nf;
    slot_t nbr;
    slot_t p;
    slot_t n;
    bit    in_range;
    r         = '0;
    r.status  = ST_OK;
    r.used_slot = idx;
    in_range  = (int'(idx) <= SLOT_COUNT);
    case (op)
      OP_INS_AFTER, OP_INS_BEFORE: begin
        if (!in_range || free_mark[idx]) begin
          r.status = ST_BAD;
        end else if (int'(elem_count) >= SLOT_COUNT || free_top == '0) begin
          r.status = ST_FULL;
        end else begin
          f               = free_top;
          nf              = next_link[f];
          slot_word[f]    = data;
          word_written[f] = 1'b1;
          free_mark[f]    = 1'b0;
          if (op == OP_INS_AFTER) begin
            nbr            = next_link[idx];
            prev_link[f]   = idx;
            next_link[f]   = nbr;
            prev_link[nbr] = f;
            next_link[idx] = f;
          end else begin
            nbr            = prev_link[idx];
            prev_link[f]   = nbr;
            next_link[f]   = idx;
            next_link[nbr] = f;
            prev_link[idx] = f;
          end
          free_top    = nf;
          elem_count  = elem_count + slot_t'(1);
          r.used_slot = f;
        end
      end
      OP_DELETE: begin
        if (elem_count == '0) begin
          r.status = ST_EMPTY;
        end else if (!in_range || idx == '0 || free_mark[idx]) begin
          r.status = ST_BAD;
        end else begin
          p                 = prev_link[idx];
          n                 = next_link[idx];
          next_link[p]      = n;
          prev_link[n]      = p;
          slot_word[idx]    = poison_copy;
          word_written[idx] = 1'b1;
          prev_link[idx]    = '0;
          next_link[idx]    = free_top;
          free_mark[idx]    = 1'b1;
          free_top          = idx;
          elem_count        = elem_count - slot_t'(1);
        end
      end
      default: begin
        if (!in_range) begin
          r.status = ST_BAD;
        end else begin
          r.read_word    = slot_word[idx];
          r.read_next    = next_link[idx];
          r.read_prev    = prev_link[idx];
          r.slot_is_free = free_mark[idx];
        end
      end
    endcase
    r.head_slot      = next_link[0];
    r.tail_slot      = prev_link[0];
    r.element_count  = elem_count;
    r.free_head_slot = free_top;
    return r;
  endfunction

  // random slot from a random start: occupied, or any slot whose word was written
  function automatic slot_t find_slot(bit any_written);
    int s0;
    int k;
    s0 = $urandom_range(1, SLOT_COUNT);
    for (int i = 0; i < SLOT_COUNT; i++) begin
      k = 1 + (s0 - 1 + i) % SLOT_COUNT;
      if (any_written ? word_written[k] : !free_mark[k]) return slot_t'(k);
    end
    return '0;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d slot %0d",
                 $time, out_status, out_used_slot);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 64'(want.status), 64'(out_status));
        check_field("used_slot", 64'(want.used_slot), 64'(out_used_slot));
        check_field("read_word", want.read_word, out_read_word);
        check_field("read_next", 64'(want.read_next), 64'(out_read_next));
        check_field("read_prev", 64'(want.read_prev), 64'(out_read_prev));
        check_field("slot_is_free", 64'(want.slot_is_free), 64'(out_slot_is_free));
        check_field("head_slot", 64'(want.head_slot), 64'(out_head_slot));
        check_field("tail_slot", 64'(want.tail_slot), 64'(out_tail_slot));
        check_field("element_count", 64'(want.element_count),
                    64'(out_element_count));
        check_field("free_head_slot", 64'(want.free_head_slot),
                    64'(out_free_head_slot));
      end
    end
  end

  // sender pacing: bursts with random gaps, unless in a steady stretch
  task automatic pace_sender();
    if (!steady) begin
      if (burst_left == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
  endtask

  // one request: hold start until taken, then predict
  task automatic send_request(op_t op, slot_t idx, word_t data);
    start         <= 1'b1;
    in_opcode     <= op;
    in_slot_index <= idx;
    in_data_word  <= data;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_list_op(op, idx, data));
    pace_sender();
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    do @(posedge clk); while (busy);
  endtask

  task automatic write_poison(word_t value);
    drain_results();
    cfg_valid       <= 1'b1;
    cfg_poison_word <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    poison_copy = value;
  endtask

  function automatic word_t random_word();
    return {$urandom(), $urandom()};
  endfunction

  // one random request; weights in percent, reads take the rest
  task automatic send_random(int ins_w, int del_w);
    int    r;
    int    pick;
    op_t   op;
    slot_t idx;
    r    = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 39) == 0) steady = !steady;
    if (r < ins_w) begin
      op = $urandom_range(0, 1) ? OP_INS_BEFORE : OP_INS_AFTER;
      if (pick < 10)      idx = slot_t'($urandom_range(0, 255));
      else if (pick < 25) idx = '0;
      else                idx = find_slot(1'b0);
    end else if (r < ins_w + del_w) begin
      op  = OP_DELETE;
      idx = (pick < 12) ? slot_t'($urandom_range(0, 255)) : find_slot(1'b0);
    end else begin
      op  = OP_READ;
      idx = (pick < 60) ? find_slot(1'b0) : find_slot(1'b1);
      if (idx == '0) idx = find_slot(1'b1);
      // nothing readable yet: insert at the sentinel instead
      if (idx == '0) op = OP_INS_AFTER;
    end
    send_request(op, idx, random_word());
  endtask

  // empty list: delete reports empty, only the sentinel takes an insert
  task automatic test_empty_list();
    send_request(OP_DELETE, slot_t'(1), '0);
    send_request(OP_DELETE, slot_t'(0), '0);
    send_request(OP_INS_AFTER, slot_t'(7), random_word());
    send_request(OP_INS_BEFORE, slot_t'(0), '1);
  endtask

  // build a short list at head, tail and middle, then read links back
  task automatic test_link_order();
    send_request(OP_INS_AFTER, slot_t'(0), '0);
    send_request(OP_INS_AFTER, slot_t'(1), 64'hA5A5_A5A5_A5A5_A5A5);
    send_request(OP_INS_BEFORE, slot_t'(2), 64'h5A5A_5A5A_5A5A_5A5A);
    send_request(OP_READ, slot_t'(1), '0);
    send_request(OP_READ, slot_t'(4), '0);
    send_request(OP_READ, slot_t'(2), '0);
    send_request(OP_READ, slot_t'(3), '0);
  endtask

  // rejected deletes and inserts, poisoning and reuse of a freed slot
  task automatic test_delete_cases();
    send_request(OP_DELETE, slot_t'(0), '0);
    send_request(OP_DELETE, slot_t'(200), '0);
    send_request(OP_DELETE, slot_t'(255), '0);
    send_request(OP_INS_AFTER, slot_t'(255), '1);
    send_request(OP_DELETE, slot_t'(1), '0);
    send_request(OP_READ, slot_t'(1), '0);
    send_request(OP_INS_BEFORE, slot_t'(0), 64'h0123_4567_89AB_CDEF);
    send_request(OP_READ, slot_t'(1), '0);
    send_request(OP_DELETE, slot_t'(4), '0);
    send_request(OP_DELETE, slot_t'(1), '0);
  endtask

  // balanced mix, with one full pause in the middle
  task automatic test_random_mix(int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain_results();
      send_random(45, 25);
    end
  endtask

  // grow the list to full, then keep pushing inserts into it
  task automatic test_fill_to_full();
    int guard;
    guard = 0;
    while (int'(elem_count) < SLOT_COUNT && guard < 900) begin
      send_random(85, 5);
      guard++;
    end
    repeat (12) send_random(60, 15);
  endtask

  // mostly deletes
  task automatic test_drain_mostly(int count);
    repeat (count) send_random(10, 70);
  endtask

  initial begin
    start           <= 1'b0;
    in_opcode       <= OP_READ;
    in_slot_index   <= '0;
    in_data_word    <= '0;
    cfg_valid       <= 1'b0;
    cfg_poison_word <= '0;
    rst_n           <= 1'b0;
    clear_list_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    write_poison('0);
    test_empty_list();
    test_link_order();
    write_poison('1);
    test_delete_cases();
    write_poison(random_word());
    test_random_mix(80);
    write_poison(64'h8000_0000_0000_0001);
    test_fill_to_full();
    write_poison(random_word());
    test_drain_mostly(130);
    write_poison('0);
    test_random_mix(40);

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run limit
  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
